### hw/rtl/vpa_pkg.sv
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared constants and types for the variable partition allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package vpa_pkg;

  localparam int unsigned TableEntriesDef = 16;
  localparam int unsigned MemSizeDef      = 4096;

  localparam int unsigned KindW   = 1;
  localparam int unsigned OwnerW  = 8;
  localparam int unsigned ReqW    = 13;
  localparam int unsigned StatusW = 3;
  localparam int unsigned AddrW   = 12;
  localparam int unsigned SizeW   = 13;
  localparam int unsigned CountW  = 5;
  localparam int unsigned FitW    = 2;

  localparam logic [StatusW-1:0] StOk      = 3'd0;
  localparam logic [StatusW-1:0] StBadSize = 3'd1;
  localparam logic [StatusW-1:0] StNoFit   = 3'd2;
  localparam logic [StatusW-1:0] StFull    = 3'd3;
  localparam logic [StatusW-1:0] StNone    = 3'd4;

  localparam logic [FitW-1:0] FitFirst = 2'd0;
  localparam logic [FitW-1:0] FitBest  = 2'd1;
  localparam logic [FitW-1:0] FitWorst = 2'd2;

  localparam logic [KindW-1:0] KindAlloc   = 1'b0;
  localparam logic [KindW-1:0] KindRelease = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture item
    logic scan_clr;   // reset scan accumulators and index
    logic scan_step;  // examine one entry for fit
    logic rel_step;   // free one entry if owned
    logic ins_setup;  // prepare split (index = count)
    logic ins_step;   // shift one entry up
    logic ins_fin;    // write split pair
    logic exact_fin;  // take chosen entry whole
    logic mrg_clr;    // reset merge pointers
    logic mrg_step;   // compact one entry
    logic mrg_fin;    // commit merged count
    logic st_clr;     // reset stats
    logic st_step;    // accumulate one entry
    logic set_status;
    logic [StatusW-1:0] status;
    logic addr_ok;
  } vpa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_release;
    logic size_zero;
    logic idx_last;   // index at last entry
    logic ins_done;   // shift reached pick+1
    logic found;
    logic exact;
    logic full;
    logic any_rel;
  } vpa_sts_t;

endpackage

`default_nettype wire

### hw/rtl/vpa_ctrl.sv
// ----------------------------------------------------------------------------
// vpa_ctrl
// Sequencer: scan, release, split shift, merge and statistics passes.
// ----------------------------------------------------------------------------
`default_nettype none

module vpa_ctrl
  import vpa_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output vpa_cmd_t      cmd_o,
  input  wire vpa_sts_t sts_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_SCAN, S_PICK, S_SHIFT, S_REL, S_MCLR, S_MRG,
    S_STCLR, S_STAT, S_OUT
  } state_e;

  state_e state_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    cmd_o = '0;
    cmd_o.status = StOk;
    case (state_q)
      S_IDLE: cmd_o.load = in_valid_i;
      S_DEC: begin
        cmd_o.scan_clr = 1'b1;
        if (!sts_i.is_release && sts_i.size_zero) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status = StBadSize;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      S_PICK: begin
        if (!sts_i.found) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status = StNoFit;
        end else if (sts_i.exact) begin
          cmd_o.exact_fin = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.addr_ok = 1'b1;
        end else if (sts_i.full) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status = StFull;
        end else begin
          cmd_o.ins_setup = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts_i.ins_done) begin
          cmd_o.ins_fin = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.addr_ok = 1'b1;
        end else begin
          cmd_o.ins_step = 1'b1;
        end
      end
      S_REL: cmd_o.rel_step = 1'b1;
      S_MCLR: begin
        if (sts_i.any_rel) begin
          cmd_o.mrg_clr = 1'b1;
        end else begin
          cmd_o.set_status = 1'b1;
          cmd_o.status = StNone;
        end
      end
      S_MRG: begin
        cmd_o.mrg_step = 1'b1;
        if (sts_i.idx_last) begin
          cmd_o.mrg_fin = 1'b1;
          cmd_o.set_status = 1'b1;
        end
      end
      S_STCLR: cmd_o.st_clr = 1'b1;
      S_STAT:  cmd_o.st_step = 1'b1;
      S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_DEC;
        S_DEC: begin
          if (sts_i.is_release) state_q <= S_REL;
          else if (sts_i.size_zero) state_q <= S_STCLR;
          else state_q <= S_SCAN;
        end
        S_SCAN:  if (sts_i.idx_last) state_q <= S_PICK;
        S_PICK: begin
          if (!sts_i.found || sts_i.exact || sts_i.full) state_q <= S_STCLR;
          else state_q <= S_SHIFT;
        end
        S_SHIFT: if (sts_i.ins_done) state_q <= S_STCLR;
        S_REL:   if (sts_i.idx_last) state_q <= S_MCLR;
        S_MCLR:  state_q <= sts_i.any_rel ? S_MRG : S_STCLR;
        S_MRG:   if (sts_i.idx_last) state_q <= S_STCLR;
        S_STCLR: state_q <= S_STAT;
        S_STAT:  if (sts_i.idx_last) state_q <= S_OUT;
        S_OUT:   if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_one_cmd_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.scan_step, cmd_o.rel_step, cmd_o.ins_step, cmd_o.mrg_step,
                cmd_o.st_step}) <= 1)
    else $error("multiple passes active");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("accept while result pending");

endmodule

`default_nettype wire

### hw/rtl/vpa_dp.sv
// ----------------------------------------------------------------------------
// vpa_dp
// Partition table, fit search, split shift, merge and statistics datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module vpa_dp
  import vpa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire vpa_cmd_t           cmd_i,
  output vpa_sts_t                sts_o,
  input  wire logic [FitW-1:0]    fit_i,
  input  wire logic [KindW-1:0]   kind_i,
  input  wire logic [OwnerW-1:0]  owner_id_i,
  input  wire logic [ReqW-1:0]    request_size_i,
  output logic [StatusW-1:0]      status_o,
  output logic [AddrW-1:0]        start_address_o,
  output logic [SizeW-1:0]        total_free_o,
  output logic [SizeW-1:0]        largest_free_o,
  output logic [SizeW-1:0]        external_fragmentation_o,
  output logic [CountW-1:0]       entries_in_use_o
);

  localparam int unsigned IdxW = $clog2(TableEntriesDef);
  localparam int unsigned CntW = $clog2(TableEntriesDef + 1);

  // table entries live in flops; each pass step touches one or two entries
  logic [AddrW-1:0]  start_q [TableEntriesDef];
  logic [SizeW-1:0]  size_q  [TableEntriesDef];
  logic [OwnerW-1:0] owner_q [TableEntriesDef];
  logic              free_q  [TableEntriesDef];
  logic [CntW-1:0]   count_q;

  logic [KindW-1:0]  kind_q;
  logic [OwnerW-1:0] own_q;
  logic [ReqW-1:0]   need_q;
  logic [IdxW-1:0]   idx_q;   // scan / shift / read pointer
  logic [IdxW-1:0]   wr_q;    // merge write pointer
  logic [CntW-1:0]   wcnt_q;  // merge entries written
  logic [IdxW-1:0]   pick_q;
  logic              found_q;
  logic              any_q;
  logic [SizeW:0]    tot_q;
  logic [SizeW-1:0]  lrg_q;
  logic [StatusW-1:0] st_q;
  logic              aok_q;
  logic [AddrW-1:0]  addr_q;

  logic [IdxW-1:0] last_idx;
  logic            fits;
  logic [IdxW-1:0] wm1;
  logic [IdxW-1:0] pick_p1;

  assign last_idx = IdxW'(count_q - CntW'(1));
  assign fits     = free_q[idx_q] && ({1'b0, size_q[idx_q]} >= {1'b0, need_q});
  assign wm1      = wr_q - IdxW'(1);
  assign pick_p1  = pick_q + IdxW'(1);

  assign sts_o.is_release = (kind_q == KindRelease);
  assign sts_o.size_zero  = (need_q == '0);
  assign sts_o.idx_last   = (idx_q == last_idx);
  assign sts_o.ins_done   = (idx_q == pick_p1);
  assign sts_o.found      = found_q;
  assign sts_o.exact      = (size_q[pick_q] == SizeW'(need_q));
  assign sts_o.full       = (count_q == CntW'(TableEntriesDef));
  assign sts_o.any_rel    = any_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CntW'(1);
      for (int i = 0; i < TableEntriesDef; i++) begin
        owner_q[i] <= '0;
        free_q[i]  <= 1'b0;
      end
      free_q[0]  <= 1'b1;
      start_q[0] <= '0;
      size_q[0]  <= SizeW'(MemSizeDef);
      found_q    <= 1'b0;
      any_q      <= 1'b0;
      idx_q      <= '0;
      wr_q       <= '0;
      wcnt_q     <= '0;
      st_q       <= StOk;
      aok_q      <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        kind_q <= kind_i;
        own_q  <= owner_id_i;
        need_q <= request_size_i;
        idx_q  <= '0;
        any_q  <= 1'b0;
        aok_q  <= 1'b0;
      end
      if (cmd_i.scan_clr) begin
        idx_q   <= '0;
        found_q <= 1'b0;
        pick_q  <= '0;
      end
      if (cmd_i.scan_step) begin
        if (fits && !(found_q && fit_i == FitFirst)) begin
          if (!found_q) begin
            found_q <= (fit_i == FitFirst) || (fit_i == FitBest) || (fit_i == FitWorst);
            pick_q  <= idx_q;
          end else if ((fit_i == FitBest && size_q[idx_q] < size_q[pick_q]) ||
                       (fit_i == FitWorst && size_q[idx_q] > size_q[pick_q])) begin
            pick_q <= idx_q;
          end
        end
        idx_q <= idx_q + IdxW'(1);
      end
      if (cmd_i.exact_fin) begin
        free_q[pick_q]  <= 1'b0;
        owner_q[pick_q] <= own_q;
        addr_q          <= start_q[pick_q];
      end
      if (cmd_i.ins_setup) idx_q <= IdxW'(count_q);
      if (cmd_i.ins_step) begin
        start_q[idx_q] <= start_q[idx_q - IdxW'(1)];
        size_q[idx_q]  <= size_q[idx_q - IdxW'(1)];
        owner_q[idx_q] <= owner_q[idx_q - IdxW'(1)];
        free_q[idx_q]  <= free_q[idx_q - IdxW'(1)];
        idx_q          <= idx_q - IdxW'(1);
      end
      if (cmd_i.ins_fin) begin
        start_q[pick_p1] <= start_q[pick_q] + AddrW'(need_q);
        size_q[pick_p1]  <= size_q[pick_q] - SizeW'(need_q);
        owner_q[pick_p1] <= '0;
        free_q[pick_p1]  <= 1'b1;
        size_q[pick_q]   <= SizeW'(need_q);
        owner_q[pick_q]  <= own_q;
        free_q[pick_q]   <= 1'b0;
        count_q          <= count_q + CntW'(1);
        addr_q           <= start_q[pick_q];
      end
      if (cmd_i.rel_step) begin
        if (!free_q[idx_q] && owner_q[idx_q] == own_q) begin
          free_q[idx_q]  <= 1'b1;
          owner_q[idx_q] <= '0;
          any_q          <= 1'b1;
        end
        idx_q <= idx_q + IdxW'(1);
      end
      if (cmd_i.mrg_clr) begin
        idx_q  <= '0;
        wr_q   <= '0;
        wcnt_q <= '0;
      end
      if (cmd_i.mrg_step) begin
        if (wcnt_q != '0 && free_q[wm1] && free_q[idx_q]) begin
          size_q[wm1] <= size_q[wm1] + size_q[idx_q];
          if (cmd_i.mrg_fin) count_q <= wcnt_q;
        end else begin
          start_q[wr_q] <= start_q[idx_q];
          size_q[wr_q]  <= size_q[idx_q];
          owner_q[wr_q] <= owner_q[idx_q];
          free_q[wr_q]  <= free_q[idx_q];
          wr_q          <= wr_q + IdxW'(1);
          wcnt_q        <= wcnt_q + CntW'(1);
          if (cmd_i.mrg_fin) count_q <= wcnt_q + CntW'(1);
        end
        idx_q <= idx_q + IdxW'(1);
      end
      if (cmd_i.st_clr) begin
        idx_q <= '0;
        tot_q <= '0;
        lrg_q <= '0;
      end
      if (cmd_i.st_step) begin
        if (free_q[idx_q]) begin
          tot_q <= tot_q + (SizeW+1)'(size_q[idx_q]);
          if (size_q[idx_q] > lrg_q) lrg_q <= size_q[idx_q];
        end
        idx_q <= idx_q + IdxW'(1);
      end
      if (cmd_i.set_status) begin
        st_q  <= cmd_i.status;
        aok_q <= cmd_i.addr_ok;
      end
    end
  end

  assign status_o                 = st_q;
  assign start_address_o          = aok_q ? addr_q : '0;
  assign total_free_o             = tot_q[SizeW-1:0];
  assign largest_free_o           = lrg_q;
  assign external_fragmentation_o = tot_q[SizeW-1:0] - lrg_q;
  assign entries_in_use_o         = CountW'(count_q);

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 && count_q <= CntW'(TableEntriesDef))
    else $error("entry count out of range");
  a_split_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_fin |=> count_q == $past(count_q) + CntW'(1))
    else $error("split did not add entry");
  a_merge_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mrg_fin |=> count_q <= $past(count_q))
    else $error("merge grew table");

endmodule

`default_nettype wire

### hw/rtl/variable_partition_allocator.sv
// ----------------------------------------------------------------------------
// variable_partition_allocator
// First/best/worst fit partition allocator with release and merge.
// ----------------------------------------------------------------------------
// One item at a time. An allocate with a split runs a fit scan over N
// entries, then a shift of the entries above the pick; a release runs an
// owner pass, then a merge pass if any entry was freed; a statistics pass
// over N entries and a result state follow every item, where N is the
// table fill. The result is held until taken; a new item is accepted after
// that.
`default_nettype none

module variable_partition_allocator
  import vpa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [FitW-1:0]    fit_strategy_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [KindW-1:0]   kind_i,
  input  wire logic [OwnerW-1:0]  owner_id_i,
  input  wire logic [ReqW-1:0]    request_size_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [StatusW-1:0]      status_o,
  output logic [AddrW-1:0]        start_address_o,
  output logic [SizeW-1:0]        total_free_o,
  output logic [SizeW-1:0]        largest_free_o,
  output logic [SizeW-1:0]        external_fragmentation_o,
  output logic [CountW-1:0]       entries_in_use_o
);

  vpa_cmd_t cmd;
  vpa_sts_t sts;
  logic [FitW-1:0] fit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_q <= FitFirst;
    end else if (cfg_valid_i) begin
      fit_q <= fit_strategy_i;
    end
  end

  vpa_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .out_valid_o,
    .out_ready_i,
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  vpa_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i  (cmd),
    .sts_o  (sts),
    .fit_i  (fit_q),
    .kind_i,
    .owner_id_i,
    .request_size_i,
    .status_o,
    .start_address_o,
    .total_free_o,
    .largest_free_o,
    .external_fragmentation_o,
    .entries_in_use_o
  );

endmodule

`default_nettype wire
